[rtl/gmws_pkg.sv]
// Package: shared constants, sequencer types and a saturating add helper for the group scorer.
package gmws_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int VAL_W          = 32;
  localparam int SUM_W          = 64;
  localparam int DIV_STEPS      = 80;
  localparam int DCNT_W         = 7;
  localparam logic [SUM_W-1:0] S64_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] S64_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_SIM   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_CMP,
    ST_SC_A,
    ST_SC_B,
    ST_SC_C,
    ST_SC_EVAL,
    ST_MUL_WW,
    ST_DIV,
    ST_T1,
    ST_MUL_HH,
    ST_MUL_HL,
    ST_MUL_LL,
    ST_T2,
    ST_OUT_S,
    ST_FIN,
    ST_FIN_Q,
    ST_OUT_F
  } state_t;

  typedef enum logic [1:0] {
    DIV_T1,
    DIV_Q,
    DIV_FIN
  } div_sel_t;

  // Signed add, clamp to the 64-bit range.
  function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
      s = a[SUM_W-1] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

[rtl/group_median_weighted_similarity.sv]
// Top level: group scorer with sorted value store, shared divider and multiplier.
//
// Each transfer on the input channel carries one point value. The block keeps the
// values of the current group sorted in a RAM by insertion: a new value walks down
// from the top of the store, one ST_INS and ST_INS_CMP pass per stored value it
// passes, so a transfer takes longer the more stored values lie above it. The input
// is not ready meanwhile. On the item that ends a group the score is read straight
// from the sorted store (the trimmed rank, or the median, averaging the two middle
// values for an even count). A counted group then runs two 80-step restoring
// divisions on one shared divider and four products on one shared 32x32 multiplier
// before the group score result is offered. On the item that ends a mode one more
// 80-step division gives the similarity (zero, with no division, when the sum of
// squared terms is not positive), offered as a second result with last set. Results
// wait in the output register until taken; the input channel stays closed until the
// last result of the item is transferred. Values past the store capacity are dropped
// and the group reports overflow. No clearing pass is needed after reset.
module group_median_weighted_similarity #(
  parameter int MAX_POINTS = gmws_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] point_value,
  input  logic [31:0] group_weight,
  input  logic        trim_mode,
  input  logic [6:0]  trim_count,
  input  logic        last_in_group,
  input  logic        last_in_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [31:0] result_value,
  output logic        group_counted,
  output logic        overflow,
  output logic        last
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = gmws_pkg::SUM_W;

  gmws_pkg::state_t   state, state_next;
  gmws_pkg::div_sel_t div_sel;

  // Control state
  logic [CW-1:0] count;
  logic          ovf_seen;
  logic [SW-1:0] inv_sum;
  logic [SW-1:0] sq_sum;

  // Item payload held for the duration of the work
  logic [31:0] x_val;
  logic [31:0] w_val;
  logic        tmode;
  logic [6:0]  tcount;
  logic        lgrp;
  logic        lmode;

  // Working registers
  logic [IW-1:0] pos;
  logic [31:0]   lo_val;
  logic [31:0]   hi_val;
  logic [31:0]   score;
  logic [31:0]   sim;
  logic          counted;
  logic          ovf_out;
  logic [SW-1:0] t1;
  logic [47:0]   hh;
  logic [39:0]   hl;
  logic [31:0]   ll;

  // Shared divider
  logic [79:0]     dnum;
  logic [SW-1:0]   dden;
  logic [SW-1:0]   drem;
  logic [SW-1:0]   quo;
  logic            qsticky;
  logic [gmws_pkg::DCNT_W-1:0] dcnt;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  gmws_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Selection of the score rank
  logic          use_trim;
  logic [IW-1:0] half_idx;
  logic [IW-1:0] addr_a;
  logic          shift_up;
  logic          store_full;

  assign use_trim   = tmode && (tcount != 7'd0) && (32'(tcount) < 32'(count));
  assign half_idx   = IW'(count >> 1);
  assign addr_a     = use_trim ? IW'(tcount) :
                      (count[0] ? half_idx : half_idx - IW'(1));
  assign shift_up   = $signed(ram_rdata) > $signed(x_val);
  assign store_full = (32'(count) >= MAX_POINTS);

  // Score from the selected rank(s); even median truncates toward zero
  logic [32:0] pair_sum;
  logic [32:0] pair_adj;
  logic [31:0] score_calc;
  logic [31:0] score_mag;

  assign pair_sum   = {lo_val[31], lo_val} + {hi_val[31], hi_val};
  assign pair_adj   = pair_sum + {32'd0, pair_sum[32]};
  assign score_calc = (!use_trim && !count[0]) ? pair_adj[32:1] : lo_val;
  assign score_mag  = score[31] ? (~score + 32'd1) : score;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] product;

  always_comb begin
    mul_a = w_val;
    mul_b = w_val;
    unique case (state)
      gmws_pkg::ST_MUL_HH: begin
        mul_a = {8'd0, quo[39:16]};
        mul_b = {8'd0, quo[39:16]};
      end
      gmws_pkg::ST_MUL_HL: begin
        mul_a = {8'd0, quo[39:16]};
        mul_b = {16'd0, quo[15:0]};
      end
      gmws_pkg::ST_MUL_LL: begin
        mul_a = {16'd0, quo[15:0]};
        mul_b = {16'd0, quo[15:0]};
      end
      default: begin
        mul_a = w_val;
        mul_b = w_val;
      end
    endcase
  end

  assign product = 64'(mul_a) * 64'(mul_b);

  // One restoring division step
  logic [SW:0]   rem_shift;
  logic          rem_ge;
  logic [SW-1:0] rem_step;

  assign rem_shift = {drem, dnum[79]};
  assign rem_ge    = rem_shift >= {1'b0, dden};
  assign rem_step  = rem_ge ? SW'(rem_shift - {1'b0, dden}) : rem_shift[SW-1:0];

  // Term arithmetic on the quotient
  logic          q_sat;
  logic [SW-1:0] t1_mag;
  logic [SW:0]   t2_sum;
  logic [SW-1:0] t2;
  logic [SW-1:0] inv_mag;
  logic [31:0]   sim_calc;

  assign q_sat  = qsticky || (quo[63:40] != 24'd0);
  assign t1_mag = (qsticky || quo[63]) ? gmws_pkg::S64_MAX : quo;
  assign t2_sum = {2'b0, hh[46:0], 16'd0} + {24'd0, hl, 1'b0} + {49'd0, ll[31:16]};
  assign t2     = (q_sat || hh[47] || t2_sum[SW] || t2_sum[SW-1]) ?
                  gmws_pkg::S64_MAX : t2_sum[SW-1:0];
  assign inv_mag = inv_sum[SW-1] ? (~inv_sum + SW'(1)) : inv_sum;

  // Clamp the similarity once the quotient leaves the 31-bit magnitude range
  always_comb begin
    if (!inv_sum[SW-1]) begin
      sim_calc = (q_sat || quo[39:31] != 9'd0) ? 32'h7FFF_FFFF : quo[31:0];
    end else begin
      sim_calc = (q_sat || quo[39:31] != 9'd0) ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
    end
  end

  // Sequencer: next state, RAM port, handshakes
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = x_val;
    ram_raddr  = pos - IW'(1);
    unique case (state)
      gmws_pkg::ST_IDLE: begin
        if (in_valid) state_next = gmws_pkg::ST_INS;
      end
      gmws_pkg::ST_INS: begin
        if (store_full) begin
          state_next = lgrp ? gmws_pkg::ST_SC_A : gmws_pkg::ST_IDLE;
        end else if (pos == '0) begin
          ram_we     = 1'b1;
          state_next = lgrp ? gmws_pkg::ST_SC_A : gmws_pkg::ST_IDLE;
        end else begin
          state_next = gmws_pkg::ST_INS_CMP;
        end
      end
      gmws_pkg::ST_INS_CMP: begin
        ram_we = 1'b1;
        if (shift_up) begin
          ram_wdata  = ram_rdata;
          state_next = gmws_pkg::ST_INS;
        end else begin
          state_next = lgrp ? gmws_pkg::ST_SC_A : gmws_pkg::ST_IDLE;
        end
      end
      gmws_pkg::ST_SC_A: begin
        ram_raddr  = addr_a;
        state_next = gmws_pkg::ST_SC_B;
      end
      gmws_pkg::ST_SC_B: begin
        ram_raddr  = half_idx;
        state_next = gmws_pkg::ST_SC_C;
      end
      gmws_pkg::ST_SC_C:   state_next = gmws_pkg::ST_SC_EVAL;
      gmws_pkg::ST_SC_EVAL: begin
        state_next = (w_val != 32'd0 && score_calc != 32'd0) ?
                     gmws_pkg::ST_MUL_WW : gmws_pkg::ST_OUT_S;
      end
      gmws_pkg::ST_MUL_WW: state_next = gmws_pkg::ST_DIV;
      gmws_pkg::ST_DIV: begin
        if (dcnt == '0) begin
          unique case (div_sel)
            gmws_pkg::DIV_T1:  state_next = gmws_pkg::ST_T1;
            gmws_pkg::DIV_Q:   state_next = gmws_pkg::ST_MUL_HH;
            gmws_pkg::DIV_FIN: state_next = gmws_pkg::ST_FIN_Q;
            default:           state_next = gmws_pkg::ST_FIN_Q;
          endcase
        end
      end
      gmws_pkg::ST_T1:     state_next = gmws_pkg::ST_DIV;
      gmws_pkg::ST_MUL_HH: state_next = gmws_pkg::ST_MUL_HL;
      gmws_pkg::ST_MUL_HL: state_next = gmws_pkg::ST_MUL_LL;
      gmws_pkg::ST_MUL_LL: state_next = gmws_pkg::ST_T2;
      gmws_pkg::ST_T2:     state_next = gmws_pkg::ST_OUT_S;
      gmws_pkg::ST_OUT_S: begin
        if (out_ready) state_next = lmode ? gmws_pkg::ST_FIN : gmws_pkg::ST_IDLE;
      end
      gmws_pkg::ST_FIN: begin
        state_next = (!sq_sum[SW-1] && sq_sum != '0) ?
                     gmws_pkg::ST_DIV : gmws_pkg::ST_OUT_F;
      end
      gmws_pkg::ST_FIN_Q:  state_next = gmws_pkg::ST_OUT_F;
      gmws_pkg::ST_OUT_F: begin
        if (out_ready) state_next = gmws_pkg::ST_IDLE;
      end
      default:             state_next = gmws_pkg::ST_IDLE;
    endcase
  end

  assign in_ready      = (state == gmws_pkg::ST_IDLE);
  assign out_valid     = (state == gmws_pkg::ST_OUT_S) || (state == gmws_pkg::ST_OUT_F);
  assign result_kind   = (state == gmws_pkg::ST_OUT_F) ? gmws_pkg::KIND_SIM
                                                       : gmws_pkg::KIND_SCORE;
  assign result_value  = (state == gmws_pkg::ST_OUT_F) ? sim : score;
  assign group_counted = (state == gmws_pkg::ST_OUT_S) && counted;
  assign overflow      = (state == gmws_pkg::ST_OUT_S) && ovf_out;
  assign last          = (state == gmws_pkg::ST_OUT_F) || !lmode;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: store fill, overflow flag and the two sums
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
      inv_sum  <= '0;
      sq_sum   <= '0;
    end else begin
      unique case (state)
        gmws_pkg::ST_INS: begin
          if (store_full) begin
            ovf_seen <= 1'b1;
          end else if (pos == '0) begin
            count <= count + CW'(1);
          end
        end
        gmws_pkg::ST_INS_CMP: begin
          if (!shift_up) count <= count + CW'(1);
        end
        gmws_pkg::ST_SC_EVAL: begin
          count    <= '0;
          ovf_seen <= 1'b0;
        end
        gmws_pkg::ST_T2: begin
          inv_sum <= gmws_pkg::sat_add64(inv_sum, t1);
          sq_sum  <= gmws_pkg::sat_add64(sq_sum, t2);
        end
        gmws_pkg::ST_FIN: begin
          if (sq_sum[SW-1] || sq_sum == '0) begin
            inv_sum <= '0;
            sq_sum  <= '0;
          end
        end
        gmws_pkg::ST_FIN_Q: begin
          inv_sum <= '0;
          sq_sum  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      gmws_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_val  <= point_value;
          w_val  <= group_weight;
          tmode  <= trim_mode;
          tcount <= trim_count;
          lgrp   <= last_in_group;
          lmode  <= last_in_mode;
          pos    <= IW'(count);
        end
      end
      gmws_pkg::ST_INS_CMP: begin
        if (shift_up) pos <= pos - IW'(1);
      end
      gmws_pkg::ST_SC_B: lo_val <= ram_rdata;
      gmws_pkg::ST_SC_C: hi_val <= ram_rdata;
      gmws_pkg::ST_SC_EVAL: begin
        score   <= score_calc;
        ovf_out <= ovf_seen;
        counted <= (w_val != 32'd0 && score_calc != 32'd0);
      end
      gmws_pkg::ST_MUL_WW: begin
        // w*w over |s|
        dnum    <= {16'd0, product};
        dden    <= {32'd0, score_mag};
        drem    <= '0;
        quo     <= '0;
        qsticky <= 1'b0;
        dcnt    <= gmws_pkg::DCNT_W'(gmws_pkg::DIV_STEPS - 1);
        div_sel <= gmws_pkg::DIV_T1;
      end
      gmws_pkg::ST_DIV: begin
        dnum    <= {dnum[78:0], 1'b0};
        drem    <= rem_step;
        quo     <= {quo[SW-2:0], rem_ge};
        qsticky <= qsticky | quo[SW-1];
        dcnt    <= dcnt - gmws_pkg::DCNT_W'(1);
      end
      gmws_pkg::ST_T1: begin
        t1      <= score[31] ? (~t1_mag + SW'(1)) : t1_mag;
        // (w<<16) over |s|
        dnum    <= {32'd0, w_val, 16'd0};
        drem    <= '0;
        quo     <= '0;
        qsticky <= 1'b0;
        dcnt    <= gmws_pkg::DCNT_W'(gmws_pkg::DIV_STEPS - 1);
        div_sel <= gmws_pkg::DIV_Q;
      end
      gmws_pkg::ST_MUL_HH: hh <= product[47:0];
      gmws_pkg::ST_MUL_HL: hl <= product[39:0];
      gmws_pkg::ST_MUL_LL: ll <= product[31:0];
      gmws_pkg::ST_FIN: begin
        sim     <= 32'd0;
        // (|first|<<16) over second
        dnum    <= {inv_mag, 16'd0};
        dden    <= sq_sum;
        drem    <= '0;
        quo     <= '0;
        qsticky <= 1'b0;
        dcnt    <= gmws_pkg::DCNT_W'(gmws_pkg::DIV_STEPS - 1);
        div_sel <= gmws_pkg::DIV_FIN;
      end
      gmws_pkg::ST_FIN_Q: sim <= sim_calc;
      default: begin
      end
    endcase
  end

endmodule

[rtl/gmws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gmws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/gmws_check.sv]
// Checker: port-level properties of the group scorer, bound to the top level.
module gmws_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [31:0] result_value,
  input logic        group_counted,
  input logic        overflow,
  input logic        last
);

  // Never take a new item while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is offered");

  // Close the input after each transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a transfer");

  // Similarity always ends the item and carries no group flags
  a_sim_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind) |-> (last && !group_counted && !overflow))
    else $error("similarity result with wrong flags");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_value)))
    else $error("stalled result changed");

endmodule

bind group_median_weighted_similarity gmws_check u_gmws_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .result_value (result_value),
  .group_counted(group_counted),
  .overflow     (overflow),
  .last         (last)
);
